[rtl/core/ssmd_pkg.sv]
// ssmd_pkg: shared types, command codes and glyph table for the
// seven-segment multiplexed display driver.
// No dependencies.
`default_nettype none

package ssmd_pkg;

    // Command codes carried in s_axis_tuser
    localparam logic [2:0] FUNC_RAW     = 3'd0;
    localparam logic [2:0] FUNC_CHAR    = 3'd1;
    localparam logic [2:0] FUNC_DECIMAL = 3'd2;
    localparam logic [2:0] FUNC_CLEAR   = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    localparam logic [7:0] GLYPH_FIRST = 8'h2D;
    localparam logic [7:0] GLYPH_LAST  = 8'h7C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] BLANK_CODE  = 8'h2C;

    // ceil(2^35 / 10): q = (x * RECIP_10) >> 35 is exact for any 32-bit x
    localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] GLYPH_ROM [80] = '{
        8'h40, 8'h00, 8'h00, 8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
        8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f, 8'h30, 8'h20, 8'h10,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 8'h7f, 8'h39, 8'h3f,
        8'h79, 8'h71, 8'h3d, 8'h76, 8'h06, 8'h1e, 8'h00, 8'h38,
        8'h00, 8'h94, 8'h3f, 8'h73, 8'h67, 8'h31, 8'h6d, 8'h7c,
        8'h3e, 8'h00, 8'h00, 8'h00, 8'h66, 8'h00, 8'h39, 8'h00,
        8'h0f, 8'h00, 8'h08, 8'h00, 8'h77, 8'h7c, 8'h58, 8'h5e,
        8'h7b, 8'h71, 8'h6f, 8'h74, 8'h04, 8'h1e, 8'h00, 8'h38,
        8'h00, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h6d, 8'h78,
        8'h1c, 8'h00, 8'h00, 8'h00, 8'h66, 8'h00, 8'h70, 8'h46
    };

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIG  = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_FILL = 5'b10000
    } t_state;

    // ASCII to segment byte; codes outside the table are blank
    function automatic logic [7:0] glyph_of(input logic [7:0] code);
        logic [7:0] idx;
        begin
            idx = code - GLYPH_FIRST;
            if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
                return GLYPH_ROM[idx[6:0]];
            end
            return 8'h00;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/seven_segment_mux_display.sv]
// Seven-segment multiplexed display driver, top level.
// Depends on ssmd_pkg (command codes, glyph table, sequencer states).
// Raw, character, clear and scan-tick words finish in the accept cycle; a tick's
// port word is on m_axis the next cycle. A decimal write steps through ST_MUL and
// ST_DIG for each digit, then ST_SIGN and ST_FILL (the blanks up to the field end):
// each digit is one pass through one shared 32x32 reciprocal multiplier and a
// remainder step. s_axis_tready is low while a decimal write runs. i_rst_n
// (synchronous, low) blanks all digits, sets the scan to digit 0 and empties the
// output register.
`default_nettype none

module seven_segment_mux_display #(
    parameter int NUM_DIGITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: one command word
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: position[3:0], field_end[7:4], segments[15:8],
    //        char_code[23:16], number[55:24]
    input  wire logic [55:0] s_axis_tdata,
    // tuser: func[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // master side: one port word per scan tick
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: port_word[15:0], scan_digit[18:16], zero[23:19]
    output logic [23:0]      m_axis_tdata
);
    import ssmd_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // unpacked command fields
    logic [2:0]  in_func;
    logic [3:0]  in_pos;
    logic [3:0]  in_endp;
    logic [7:0]  in_seg;
    logic [7:0]  in_char;
    logic [31:0] in_num;

    assign in_func = s_axis_tuser;
    assign in_pos  = s_axis_tdata[3:0];
    assign in_endp = s_axis_tdata[7:4];
    assign in_seg  = s_axis_tdata[15:8];
    assign in_char = s_axis_tdata[23:16];
    assign in_num  = s_axis_tdata[55:24];

    // digit store and scan pointer
    logic [7:0]       r_digits [NUM_DIGITS];
    logic [IDX_W-1:0] r_scan;

    // decimal sequencer
    t_state      r_state, n_state;
    logic [31:0] r_mag, n_mag;      // remaining magnitude
    logic [28:0] r_quot, n_quot;    // mag / 10 from the multiplier pass
    logic        r_neg, n_neg;
    logic [3:0]  r_pos, n_pos;      // next digit to write, can reach 9
    logic [3:0]  r_endp, n_endp;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic [2:0]  r_out_digit;

    logic        accept;
    logic        tick_blocked;
    logic        do_clear;
    logic        do_tick;
    logic        wr_en;
    logic [3:0]  wr_pos;
    logic [7:0]  wr_data;
    logic [63:0] prod;
    logic [31:0] quot10;
    logic [3:0]  rem;
    logic [4:0]  pos_inc;

    // a tick needs the output register free; other commands never wait on it
    assign tick_blocked  = (in_func == FUNC_TICK) && r_out_valid && !m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !tick_blocked;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // shared divide-by-ten unit: multiplier pass, then remainder pass
    assign prod    = 64'(r_mag) * 64'(RECIP_10);
    assign quot10  = (32'(r_quot) << 3) + (32'(r_quot) << 1);
    assign rem     = 4'(r_mag - quot10);
    assign pos_inc = {1'b0, r_pos} + 5'd1;

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_quot   = r_quot;
        n_neg    = r_neg;
        n_pos    = r_pos;
        n_endp   = r_endp;
        wr_en    = 1'b0;
        wr_pos   = r_pos;
        wr_data  = 8'h00;
        do_clear = 1'b0;
        do_tick  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_func)
                        FUNC_RAW: begin
                            wr_en   = 1'b1;
                            wr_pos  = in_pos;
                            wr_data = in_seg;
                        end
                        FUNC_CHAR: begin
                            wr_en   = 1'b1;
                            wr_pos  = in_pos;
                            wr_data = glyph_of(in_char);
                        end
                        FUNC_DECIMAL: begin
                            // an end past the last digit drops the word
                            if (in_endp <= 4'(NUM_DIGITS)) begin
                                n_neg   = in_num[31];
                                n_mag   = in_num[31] ? (32'd0 - in_num) : in_num;
                                n_pos   = 4'd0;
                                n_endp  = in_endp;
                                n_state = ST_MUL;
                            end
                        end
                        FUNC_CLEAR: do_clear = 1'b1;
                        FUNC_TICK:  do_tick  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                n_quot  = prod[63:RECIP_SHIFT];
                n_state = ST_DIG;
            end
            ST_DIG: begin
                wr_en   = 1'b1;
                wr_data = glyph_of(CHAR_ZERO + 8'(rem));
                n_mag   = 32'(r_quot);
                n_pos   = pos_inc[3:0];
                // lowest digit always written; stop on zero quotient or field end
                if (r_quot != 29'd0 && pos_inc < {1'b0, r_endp}) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (r_neg) begin
                    wr_en   = 1'b1;
                    wr_data = glyph_of(CHAR_MINUS);
                    n_pos   = pos_inc[3:0];
                end
                n_state = ST_FILL;
            end
            ST_FILL: begin
                if (r_pos < r_endp) begin
                    wr_en   = 1'b1;
                    wr_data = glyph_of(BLANK_CODE);
                    n_pos   = pos_inc[3:0];
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag  <= n_mag;
        r_quot <= n_quot;
        r_neg  <= n_neg;
        r_pos  <= n_pos;
        r_endp <= n_endp;
    end

    // digit store: cleared by reset or clear, else one write per cycle, positions past the last digit dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_clear) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digits[i] <= 8'h00;
            end
        end else if (wr_en && wr_pos < 4'(NUM_DIGITS)) begin
            r_digits[wr_pos[IDX_W-1:0]] <= wr_data;
        end
    end

    // scan: emit the current digit, then step with wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else if (do_tick) begin
            r_out_valid <= 1'b1;
            if (r_scan == IDX_W'(NUM_DIGITS - 1)) begin
                r_scan <= '0;
            end else begin
                r_scan <= r_scan + IDX_W'(1);
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (do_tick) begin
            r_out_word  <= {8'(8'd1 << r_scan), r_digits[r_scan]};
            r_out_digit <= 3'(r_scan);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_digit, r_out_word};

endmodule

`default_nettype wire

[rtl/core/ssmd_checker.sv]
// ssmd_checker: port-level assertions for the display driver, plus bind.
// Depends on ssmd_pkg and seven_segment_mux_display.
`default_nettype none

module ssmd_checker #(
    parameter int NUM_DIGITS = 8
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [55:0] s_axis_tdata,
    input wire logic [2:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    import ssmd_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // common drive matches the reported digit, which stays in range
    a_common: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:8] == 8'(8'd1 << m_axis_tdata[18:16])
            && {1'b0, m_axis_tdata[18:16]} < 4'(NUM_DIGITS)
            && m_axis_tdata[23:19] == 5'd0)
        else $error("common bits do not match scan digit");

    // a valid decimal write keeps the input side busy next cycle
    a_dec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_DECIMAL
            && s_axis_tdata[7:4] <= 4'(NUM_DIGITS) |=> !s_axis_tready)
        else $error("ready during decimal write");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind seven_segment_mux_display ssmd_checker #(.NUM_DIGITS(NUM_DIGITS)) u_ssmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
